// ===== src/skset_pkg.sv =====
// shared constants, opcodes and the sequencer state type for the sorted key set
// no dependencies; used by skset_ram users and the sorted_key_set top level
package skset_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 31;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_CONTAINS = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_UP_RD = 8'b0000_1000,
        S_UP_WR = 8'b0001_0000,
        S_DN_RD = 8'b0010_0000,
        S_DN_WR = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

// ===== src/sorted_key_set.sv =====
// sorted key set: a set of distinct 31-bit keys kept in ascending order in a ram.
// A request on i_valid/i_op/i_key is taken when o_stall is low; o_stall is high
// from the cycle after acceptance until the request is finished, so one request
// is in work at a time. op 0 asks whether the key is held, op 1 adds it, op 2
// removes it; op 3 changes nothing and answers 0.
// Each request gives one result on o_valid/o_success/o_full_error, held until
// the cycle in which i_stall is low. A finished result waits in the output
// register while the next request is already being taken and worked.
// Steps: the key is located with one ram read and one compare a step, a gap is
// opened or closed with one ram read and one ram write per moved key, and then
// the result is posted.
// Throughput is set by the single ram port pair and the one shared comparator.
// Reset empties the set by clearing the key count; the ram needs no clearing pass.
// If the output register still holds a stalled result, the next result waits.
// Depends on skset_pkg and skset_ram.
module sorted_key_set (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [1:0]                  i_op,
    input  logic [skset_pkg::KEY_W-1:0] i_key,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic                        o_success,
    output logic                        o_full_error,
    input  logic                        i_stall
);

    localparam int IDX_W = skset_pkg::IDX_W;
    localparam int CNT_W = skset_pkg::CNT_W;
    localparam int KEY_W = skset_pkg::KEY_W;

    skset_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [1:0]        r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic              r_res_success, n_res_success;
    logic              r_res_full, n_res_full;
    logic              r_out_valid, n_out_valid;
    logic              r_out_success, n_out_success;
    logic              r_out_full, n_out_full;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    logic              loc_done;
    logic              loc_here;
    logic              in_take;
    logic              out_free;
    logic [CNT_W-1:0]  idx_inc;

    assign o_stall  = (r_state != skset_pkg::S_IDLE);
    assign in_take  = i_valid && (r_state == skset_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign idx_inc  = r_idx + CNT_W'(1);

    // shared compare: search ends at the first stored key not below the request, or past the last stored key
    always_comb begin
        loc_done = 1'b0;
        loc_here = 1'b0;
        if (r_state == skset_pkg::S_READ) begin
            loc_done = (r_idx == r_count);
        end else if (r_state == skset_pkg::S_CMP) begin
            loc_done = !(ram_rdata < r_key);
            loc_here = (ram_rdata == r_key);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_op          = r_op;
        n_key         = r_key;
        n_res_success = r_res_success;
        n_res_full    = r_res_full;
        n_out_valid   = r_out_valid;
        n_out_success = r_out_success;
        n_out_full    = r_out_full;
        ram_we        = 1'b0;
        ram_waddr     = r_idx[IDX_W-1:0];
        ram_wdata     = r_key;
        ram_raddr     = r_idx[IDX_W-1:0];

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            skset_pkg::S_IDLE: begin
                if (in_take) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_idx   = '0;
                    n_state = skset_pkg::S_READ;
                end
            end
            skset_pkg::S_READ,
            skset_pkg::S_CMP: begin
                if (r_state == skset_pkg::S_READ && !loc_done) begin
                    n_state = skset_pkg::S_CMP;
                end else if (r_state == skset_pkg::S_CMP && !loc_done) begin
                    n_idx   = idx_inc;
                    n_state = skset_pkg::S_READ;
                end else begin
                    // key located at r_idx; choose what the request does
                    n_res_success = 1'b0;
                    n_res_full    = 1'b0;
                    n_state       = skset_pkg::S_DONE;
                    case (r_op)
                        skset_pkg::OP_CONTAINS: begin
                            n_res_success = loc_here;
                        end
                        skset_pkg::OP_ADD: begin
                            if (!loc_here) begin
                                if (r_count == CNT_W'(skset_pkg::CAPACITY)) begin
                                    n_res_full = 1'b1;
                                end else begin
                                    n_key   = r_key;
                                    n_state = skset_pkg::S_UP_RD;
                                end
                            end
                        end
                        skset_pkg::OP_REMOVE: begin
                            if (loc_here) begin
                                n_state = skset_pkg::S_DN_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // shifting states use r_idx as the insert or remove position and the
        // dedicated walker below
    end

    // walker for the gap shift: one ram read then one ram write per moved key
    logic [CNT_W-1:0] r_walk, n_walk;
    logic [CNT_W-1:0] walk_inc;
    logic [CNT_W-1:0] walk_dec;
    logic             sh_we;
    logic [IDX_W-1:0] sh_waddr;
    logic [KEY_W-1:0] sh_wdata;
    logic [IDX_W-1:0] sh_raddr;
    skset_pkg::t_state sh_state;
    logic             sh_active;
    logic             sh_finish;

    assign walk_inc = r_walk + CNT_W'(1);
    assign walk_dec = r_walk - CNT_W'(1);

    always_comb begin
        n_walk    = r_walk;
        sh_we     = 1'b0;
        sh_waddr  = r_walk[IDX_W-1:0];
        sh_wdata  = ram_rdata;
        sh_raddr  = r_walk[IDX_W-1:0];
        sh_state  = r_state;
        sh_active = 1'b0;
        sh_finish = 1'b0;
        case (r_state)
            skset_pkg::S_READ,
            skset_pkg::S_CMP: begin
                // start the walker at the top for insert, at the hit for remove
                n_walk = (r_op == skset_pkg::OP_ADD) ? r_count : r_idx;
            end
            skset_pkg::S_UP_RD: begin
                sh_active = 1'b1;
                if (r_walk == r_idx) begin
                    sh_we     = 1'b1;
                    sh_wdata  = r_key;
                    sh_finish = 1'b1;
                    sh_state  = skset_pkg::S_DONE;
                end else begin
                    sh_raddr = walk_dec[IDX_W-1:0];
                    sh_state = skset_pkg::S_UP_WR;
                end
            end
            skset_pkg::S_UP_WR: begin
                sh_active = 1'b1;
                sh_we     = 1'b1;
                n_walk    = walk_dec;
                sh_state  = skset_pkg::S_UP_RD;
            end
            skset_pkg::S_DN_RD: begin
                sh_active = 1'b1;
                if (walk_inc >= r_count) begin
                    sh_finish = 1'b1;
                    sh_state  = skset_pkg::S_DONE;
                end else begin
                    sh_raddr = walk_inc[IDX_W-1:0];
                    sh_state = skset_pkg::S_DN_WR;
                end
            end
            skset_pkg::S_DN_WR: begin
                sh_active = 1'b1;
                sh_we     = 1'b1;
                n_walk    = walk_inc;
                sh_state  = skset_pkg::S_DN_RD;
            end
            default: begin
            end
        endcase
    end

    // final next-state merge of search, shift and result posting
    skset_pkg::t_state m_state;
    logic [CNT_W-1:0]  m_count;
    logic              m_res_success;
    logic              m_out_valid;
    logic              m_out_success;
    logic              m_out_full;

    always_comb begin
        m_state       = n_state;
        m_count       = n_count;
        m_res_success = n_res_success;
        m_out_valid   = n_out_valid;
        m_out_success = n_out_success;
        m_out_full    = n_out_full;
        if (sh_active) begin
            m_state = sh_state;
            if (sh_finish) begin
                m_res_success = 1'b1;
                m_count = (r_state == skset_pkg::S_UP_RD) ? (r_count + CNT_W'(1))
                                                          : (r_count - CNT_W'(1));
            end
        end
        if (r_state == skset_pkg::S_DONE && out_free) begin
            m_out_valid   = 1'b1;
            m_out_success = r_res_success;
            m_out_full    = r_res_full;
            m_state       = skset_pkg::S_IDLE;
        end
    end

    logic              u_we;
    logic [IDX_W-1:0]  u_waddr;
    logic [KEY_W-1:0]  u_wdata;
    logic [IDX_W-1:0]  u_raddr;

    always_comb begin
        u_we    = ram_we;
        u_waddr = ram_waddr;
        u_wdata = ram_wdata;
        u_raddr = ram_raddr;
        if (sh_active) begin
            u_we    = sh_we;
            u_waddr = sh_waddr;
            u_wdata = sh_wdata;
            u_raddr = sh_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skset_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= m_state;
            r_count     <= m_count;
            r_out_valid <= m_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_walk        <= n_walk;
        r_op          <= n_op;
        r_key         <= n_key;
        r_res_success <= m_res_success;
        r_res_full    <= n_res_full;
        r_out_success <= m_out_success;
        r_out_full    <= m_out_full;
    end

    assign o_valid      = r_out_valid;
    assign o_success    = r_out_success;
    assign o_full_error = r_out_full;

    // the ram is driven from the merged port signals
    skset_ram #(
        .DEPTH (skset_pkg::CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== src/skset_ram.sv =====
// generic single-clock ram: one write port, one read port with registered data
// standalone; sized by its parameters
module skset_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
